// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module.
// Assumes clk and rst_n are visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define TPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define TPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tpa_pkg.sv =====
// Shared types and constants for the triangle primitive assembler.
// No dependencies.
package tpa_pkg;

    localparam int VERTEX_DEPTH = 4096;
    localparam int VIDX_W       = $clog2(VERTEX_DEPTH);
    localparam int COEF_W       = 21;
    localparam int ROW_W        = 3 * COEF_W;
    localparam int CNT_W        = 13;
    localparam int QUEUE_DEPTH  = 4;
    localparam int DET_SETTLE   = 4;

    localparam logic [ROW_W-1:0] ROW_X_RST = ROW_W'(64'd65536);
    localparam logic [ROW_W-1:0] ROW_Y_RST = ROW_W'(64'd65536 << 21);
    localparam logic [ROW_W-1:0] ROW_Z_RST = ROW_W'(64'd65536 << 42);

    typedef enum logic [1:0] {
        CMD_VERTEX = 2'd0,
        CMD_STRIP  = 2'd1,
        CMD_LIST   = 2'd2,
        CMD_FAN    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_ROW_X   = 3'd0,
        REG_ROW_Y   = 3'd1,
        REG_ROW_Z   = 3'd2,
        REG_SHIFT_X = 3'd3,
        REG_SHIFT_Y = 3'd4,
        REG_SHIFT_Z = 3'd5,
        REG_SOLID   = 3'd6,
        REG_VCOUNT  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [11:0]        vertex_slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        vert_index;
        logic               group_end;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] corner_a_x;
        logic signed [31:0] corner_a_y;
        logic signed [31:0] corner_a_z;
        logic signed [31:0] corner_b_x;
        logic signed [31:0] corner_b_y;
        logic signed [31:0] corner_b_z;
        logic signed [31:0] corner_c_x;
        logic signed [31:0] corner_c_y;
        logic signed [31:0] corner_c_z;
    } out_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]   row_x;
        logic [ROW_W-1:0]   row_y;
        logic [ROW_W-1:0]   row_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
        logic               solid_reversed;
        logic [CNT_W-1:0]   vertex_count;
    } cfg_t;

    // queue entry: vertex write (addr_a = slot) or triangle in emitted order
    typedef struct packed {
        logic               is_tri;
        logic [VIDX_W-1:0]  addr_a;
        logic [VIDX_W-1:0]  addr_b;
        logic [VIDX_W-1:0]  addr_c;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } qent_t;

endpackage

// ===== rtl/core/triangle_primitive_assembler_unit.sv =====
// Top level of the triangle primitive assembler: APB registers and block wiring.
// Depends on tpa_pkg, tpa_det, tpa_front, tpa_queue, tpa_back.

// Takes one item per clock, vertex write or index, while the queue has room and
// the winding sign has settled, and sends at most one triangle per clock through
// the queue, the store read, product and output registers. The three corners
// are read from three copies of the vertex store at once and transformed by 27
// parallel multipliers. A 4-entry queue sits between assembly and transform.
// After every register write the input is held off while the determinant
// pipeline recomputes the winding sign. The store has no reset or clearing pass.
module triangle_primitive_assembler_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tpa_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tpa_pkg::out_item_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import tpa_pkg::*;

    cfg_t     cfg_reg;
    logic     cfg_wr;
    reg_idx_t ridx;
    logic     det_neg, det_ready;
    logic     q_full, q_empty, q_pop, push;
    qent_t    push_data, q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign ridx   = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_x          <= ROW_X_RST;
            cfg_reg.row_y          <= ROW_Y_RST;
            cfg_reg.row_z          <= ROW_Z_RST;
            cfg_reg.shift_x        <= '0;
            cfg_reg.shift_y        <= '0;
            cfg_reg.shift_z        <= '0;
            cfg_reg.solid_reversed <= 1'b0;
            cfg_reg.vertex_count   <= '0;
        end
        else if (cfg_wr)
        begin
            case (ridx)
                REG_ROW_X:   cfg_reg.row_x          <= pwdata[ROW_W-1:0];
                REG_ROW_Y:   cfg_reg.row_y          <= pwdata[ROW_W-1:0];
                REG_ROW_Z:   cfg_reg.row_z          <= pwdata[ROW_W-1:0];
                REG_SHIFT_X: cfg_reg.shift_x        <= pwdata[31:0];
                REG_SHIFT_Y: cfg_reg.shift_y        <= pwdata[31:0];
                REG_SHIFT_Z: cfg_reg.shift_z        <= pwdata[31:0];
                REG_SOLID:   cfg_reg.solid_reversed <= pwdata[0];
                REG_VCOUNT:  cfg_reg.vertex_count   <= pwdata[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_ROW_X:   prdata = 64'(cfg_reg.row_x);
            REG_ROW_Y:   prdata = 64'(cfg_reg.row_y);
            REG_ROW_Z:   prdata = 64'(cfg_reg.row_z);
            REG_SHIFT_X: prdata = {32'h0, cfg_reg.shift_x};
            REG_SHIFT_Y: prdata = {32'h0, cfg_reg.shift_y};
            REG_SHIFT_Z: prdata = {32'h0, cfg_reg.shift_z};
            REG_SOLID:   prdata = 64'(cfg_reg.solid_reversed);
            REG_VCOUNT:  prdata = 64'(cfg_reg.vertex_count);
            default:     prdata = '0;
        endcase
    end

    tpa_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_wr    (cfg_wr),
        .det_neg   (det_neg),
        .det_ready (det_ready)
    );

    tpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .det_neg   (det_neg),
        .det_ready (det_ready),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    tpa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    tpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/core/tpa_det.sv =====
// Pipelined sign of the 3x3 matrix determinant, with settle tracking.
// Depends on tpa_pkg.
module tpa_det (
    input  logic          clk,
    input  logic          rst_n,
    input  tpa_pkg::cfg_t cfg,
    input  logic          cfg_wr,
    output logic          det_neg,
    output logic          det_ready
);
    import tpa_pkg::*;

    localparam int SET_W = $clog2(DET_SETTLE + 1);

    logic signed [COEF_W-1:0] m [9];
    logic signed [41:0] p_reg [6];
    logic signed [42:0] d_reg [3];
    logic signed [42:0] ph_reg [3];
    logic signed [42:0] pl_reg [3];
    logic signed [67:0] t [3];
    logic signed [67:0] det;
    logic               neg_reg;
    logic [SET_W-1:0]   settle_reg;
    logic [SET_W-1:0]   settle_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            m[3*k]     = cfg.row_x[COEF_W*k +: COEF_W];
            m[3*k + 1] = cfg.row_y[COEF_W*k +: COEF_W];
            m[3*k + 2] = cfg.row_z[COEF_W*k +: COEF_W];
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg[0] <= m[4] * m[8];
        p_reg[1] <= m[5] * m[7];
        p_reg[2] <= m[1] * m[8];
        p_reg[3] <= m[2] * m[7];
        p_reg[4] <= m[1] * m[5];
        p_reg[5] <= m[2] * m[4];
        d_reg[0] <= 43'(p_reg[0]) - 43'(p_reg[1]);
        d_reg[1] <= 43'(p_reg[2]) - 43'(p_reg[3]);
        d_reg[2] <= 43'(p_reg[4]) - 43'(p_reg[5]);
        for (int k = 0; k < 3; k++)
        begin
            ph_reg[k] <= m[3*k] * $signed(d_reg[k][42:21]);
            pl_reg[k] <= m[3*k] * $signed({1'b0, d_reg[k][20:0]});
        end
        neg_reg <= det[67];
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t[k] = ($signed({{4{ph_reg[k][42]}}, ph_reg[k]}) <<< 21) + 68'(pl_reg[k]);
        end
        det = t[0] - t[1] + t[2];
    end

    always_comb
    begin
        settle_next = settle_reg;
        if (cfg_wr)
        begin
            settle_next = SET_W'(DET_SETTLE);
        end
        else if (settle_reg != '0)
        begin
            settle_next = settle_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= SET_W'(DET_SETTLE);
        end
        else
        begin
            settle_reg <= settle_next;
        end
    end

    assign det_neg   = neg_reg;
    assign det_ready = (settle_reg == '0);

endmodule

// ===== rtl/core/tpa_front.sv =====
// Front end: accepts items, runs strip/list/fan assembly, culls bad indices.
// Depends on tpa_pkg; feeds tpa_queue.
module tpa_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tpa_pkg::in_item_t in_data,
    input  tpa_pkg::cfg_t     cfg,
    input  logic              det_neg,
    input  logic              det_ready,
    input  logic              q_full,
    output logic              push,
    output tpa_pkg::qent_t    push_data
);
    import tpa_pkg::*;

    logic [15:0] anchor_reg, anchor_next;
    logic [15:0] older_reg, older_next;
    logic [15:0] newer_reg, newer_next;
    logic [1:0]  fill_reg, fill_next;
    logic        odd_reg, odd_next;
    logic        acc;
    logic        emit;
    logic        rev;
    logic        base;
    logic        all_ok;
    logic        slot_ok;
    logic [15:0] ia, ib, ic;

    function automatic logic idx_ok(input logic [15:0] idx, input logic [CNT_W-1:0] cnt);
        idx_ok = (32'(idx) < 32'(cnt)) && (32'(idx) < VERTEX_DEPTH);
    endfunction

    assign in_ready = det_ready && !q_full;
    assign acc      = in_valid && in_ready;
    assign base     = cfg.solid_reversed ^ det_neg;

    always_comb
    begin
        anchor_next = anchor_reg;
        older_next  = older_reg;
        newer_next  = newer_reg;
        fill_next   = fill_reg;
        odd_next    = odd_reg;
        emit        = 1'b0;
        rev         = base;
        ia          = older_reg;
        ib          = newer_reg;
        ic          = in_data.vert_index;
        case (in_data.cmd)
            CMD_STRIP:
            begin
                case (fill_reg)
                    2'd0:
                    begin
                        newer_next = in_data.vert_index;
                        fill_next  = 2'd1;
                    end
                    2'd1:
                    begin
                        older_next = newer_reg;
                        newer_next = in_data.vert_index;
                        fill_next  = 2'd2;
                    end
                    default:
                    begin
                        emit       = 1'b1;
                        rev        = base ^ odd_reg;
                        older_next = newer_reg;
                        newer_next = in_data.vert_index;
                        odd_next   = !odd_reg;
                    end
                endcase
            end
            CMD_LIST:
            begin
                case (fill_reg)
                    2'd0:
                    begin
                        older_next = in_data.vert_index;
                        fill_next  = 2'd1;
                    end
                    2'd1:
                    begin
                        newer_next = in_data.vert_index;
                        fill_next  = 2'd2;
                    end
                    default:
                    begin
                        emit      = 1'b1;
                        fill_next = 2'd0;
                    end
                endcase
            end
            CMD_FAN:
            begin
                ia = anchor_reg;
                case (fill_reg)
                    2'd0:
                    begin
                        anchor_next = in_data.vert_index;
                        fill_next   = 2'd1;
                    end
                    2'd1:
                    begin
                        newer_next = in_data.vert_index;
                        fill_next  = 2'd2;
                    end
                    default:
                    begin
                        emit       = 1'b1;
                        newer_next = in_data.vert_index;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        if (in_data.cmd != CMD_VERTEX && in_data.group_end)
        begin
            fill_next = 2'd0;
            odd_next  = 1'b0;
        end
    end

    assign all_ok  = idx_ok(ia, cfg.vertex_count) && idx_ok(ib, cfg.vertex_count)
                     && idx_ok(ic, cfg.vertex_count);
    assign slot_ok = 32'(in_data.vertex_slot) < VERTEX_DEPTH;

    always_comb
    begin
        push_data.is_tri = (in_data.cmd != CMD_VERTEX);
        push_data.addr_b = VIDX_W'(ib);
        push_data.pos_x  = in_data.pos_x;
        push_data.pos_y  = in_data.pos_y;
        push_data.pos_z  = in_data.pos_z;
        if (in_data.cmd == CMD_VERTEX)
        begin
            push_data.addr_a = VIDX_W'(in_data.vertex_slot);
            push_data.addr_c = VIDX_W'(ic);
            push = acc && slot_ok;
        end
        else
        begin
            push_data.addr_a = rev ? VIDX_W'(ic) : VIDX_W'(ia);
            push_data.addr_c = rev ? VIDX_W'(ia) : VIDX_W'(ic);
            push = acc && emit && all_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_reg <= '0;
            older_reg  <= '0;
            newer_reg  <= '0;
            fill_reg   <= '0;
            odd_reg    <= 1'b0;
        end
        else if (acc)
        begin
            anchor_reg <= anchor_next;
            older_reg  <= older_next;
            newer_reg  <= newer_next;
            fill_reg   <= fill_next;
            odd_reg    <= odd_next;
        end
    end

endmodule

// ===== rtl/core/tpa_queue.sv =====
// Short FIFO of work entries between front and back ends.
// Depends on tpa_pkg.
module tpa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tpa_pkg::qent_t push_data,
    input  logic           pop,
    output tpa_pkg::qent_t head,
    output logic           empty,
    output logic           full
);
    import tpa_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    qent_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_QW-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_QW'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/tpa_back.sv =====
// Back end: vertex store (three read copies), affine transform, output register.
// Depends on tpa_pkg; drains tpa_queue.
module tpa_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tpa_pkg::cfg_t      cfg,
    input  logic               q_empty,
    input  tpa_pkg::qent_t     q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output tpa_pkg::out_item_t out_data
);
    import tpa_pkg::*;

    logic [95:0] mem_a [VERTEX_DEPTH];
    logic [95:0] mem_b [VERTEX_DEPTH];
    logic [95:0] mem_c [VERTEX_DEPTH];
    logic [95:0] rd_reg [3];

    logic signed [52:0] prod_reg [3][3][3];
    logic signed [31:0] res [3][3];
    logic signed [COEF_W-1:0] cf [3][3];
    logic signed [31:0] shf [3];
    logic [95:0] wdata;

    logic v1_reg, v2_reg, v3_reg;
    logic en, wr_en, rd_en;
    out_item_t out_reg, out_next;

    function automatic logic signed [31:0] round_sat(
        input logic signed [52:0] p0,
        input logic signed [52:0] p1,
        input logic signed [52:0] p2,
        input logic signed [31:0] s
    );
        logic signed [55:0] acc;
        logic signed [55:0] sh;
        acc = 56'(p0) + 56'(p1) + 56'(p2) + ($signed({{8{s[31]}}, s, 16'h0000}))
              + 56'sd32768;
        sh = acc >>> 16;
        if (sh > 56'sd2147483647)
        begin
            round_sat = 32'sh7fffffff;
        end
        else if (sh < -56'sd2147483648)
        begin
            round_sat = 32'sh80000000;
        end
        else
        begin
            round_sat = sh[31:0];
        end
    endfunction

    assign en    = !(v3_reg && !out_ready);
    assign q_pop = en && !q_empty;
    assign wr_en = q_pop && !q_head.is_tri;
    assign rd_en = q_pop && q_head.is_tri;
    assign wdata = {q_head.pos_x, q_head.pos_y, q_head.pos_z};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[q_head.addr_a] <= wdata;
        end
        if (rd_en)
        begin
            rd_reg[0] <= mem_a[q_head.addr_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_b[q_head.addr_a] <= wdata;
        end
        if (rd_en)
        begin
            rd_reg[1] <= mem_b[q_head.addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_c[q_head.addr_a] <= wdata;
        end
        if (rd_en)
        begin
            rd_reg[2] <= mem_c[q_head.addr_c];
        end
    end

    always_comb
    begin
        for (int t = 0; t < 3; t++)
        begin
            cf[0][t] = cfg.row_x[COEF_W*t +: COEF_W];
            cf[1][t] = cfg.row_y[COEF_W*t +: COEF_W];
            cf[2][t] = cfg.row_z[COEF_W*t +: COEF_W];
        end
        shf[0] = cfg.shift_x;
        shf[1] = cfg.shift_y;
        shf[2] = cfg.shift_z;
    end

    // corner k, axis j, term t
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[k][j][0] <= cf[j][0] * $signed(rd_reg[k][95:64]);
                    prod_reg[k][j][1] <= cf[j][1] * $signed(rd_reg[k][63:32]);
                    prod_reg[k][j][2] <= cf[j][2] * $signed(rd_reg[k][31:0]);
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                res[k][j] = round_sat(prod_reg[k][j][0], prod_reg[k][j][1],
                                      prod_reg[k][j][2], shf[j]);
            end
        end
        out_next.corner_a_x = res[0][0];
        out_next.corner_a_y = res[0][1];
        out_next.corner_a_z = res[0][2];
        out_next.corner_b_x = res[1][0];
        out_next.corner_b_y = res[1][1];
        out_next.corner_b_z = res[1][2];
        out_next.corner_c_x = res[2][0];
        out_next.corner_c_y = res[2][1];
        out_next.corner_c_z = res[2][2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/tpa_checker.sv =====
// Port-level checks for the triangle primitive assembler, bound to the top.
// Depends on tpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tpa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input tpa_pkg::out_item_t out_data,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic               pready
);
    import tpa_pkg::*;

    `TPA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "out beat dropped while stalled")
    `TPA_ASSERT(a_cfg_blocks, psel && penable && pwrite |=> !in_ready, "input open right after register write")
    `TPA_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind triangle_primitive_assembler_unit tpa_checker u_tpa_checker (.*);

// ===== dv/testbench.sv =====
// Testbench for triangle_primitive_assembler_unit: strip, list and fan assembly,
// affine transform, winding and index range, checked beat by beat against a predictor.
// Depends on tpa_pkg and the RTL under rtl/core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 12;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    triangle_primitive_assembler_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // predictor state
    logic signed [31:0] vtx_x [VERTEX_DEPTH];
    logic signed [31:0] vtx_y [VERTEX_DEPTH];
    logic signed [31:0] vtx_z [VERTEX_DEPTH];
    bit                 vtx_written [VERTEX_DEPTH];
    int                 filled_slots [$];
    logic [15:0]        anchor_idx, older_idx, newer_idx;
    logic [1:0]         fill;
    logic               odd_tri;
    cfg_t               cfg;

    out_item_t tri_expected [$];
    int        errors = 0;
    bit        jitter = 1'b1;
    bit        hold_req = 1'b0;
    int        hold_cnt = 0;
    int        stall_left = 0;
    int        quiet_cycles = 0;

    function automatic longint coef_of(logic [ROW_W-1:0] row, int k);
        logic signed [COEF_W-1:0] c;
        c = row[COEF_W*k +: COEF_W];
        return longint'(c);
    endfunction

    function automatic logic [ROW_W-1:0] pack_row(int c0, int c1, int c2);
        logic [COEF_W-1:0] a, b, c;
        a = c0[COEF_W-1:0];
        b = c1[COEF_W-1:0];
        c = c2[COEF_W-1:0];
        return {c, b, a};
    endfunction

    function automatic bit winding_flips();
        longint m0, m1, m2, m3, m4, m5, m6, m7, m8, det;
        m0 = coef_of(cfg.row_x, 0); m3 = coef_of(cfg.row_x, 1); m6 = coef_of(cfg.row_x, 2);
        m1 = coef_of(cfg.row_y, 0); m4 = coef_of(cfg.row_y, 1); m7 = coef_of(cfg.row_y, 2);
        m2 = coef_of(cfg.row_z, 0); m5 = coef_of(cfg.row_z, 1); m8 = coef_of(cfg.row_z, 2);
        det = m0 * (m4 * m8 - m5 * m7) - m3 * (m1 * m8 - m2 * m7) + m6 * (m1 * m5 - m2 * m4);
        return det < 0;
    endfunction

    function automatic logic signed [31:0] xform(logic [ROW_W-1:0] row,
                                                 logic signed [31:0] shift, int i);
        longint acc;
        acc = coef_of(row, 0) * longint'(vtx_x[i]) + coef_of(row, 1) * longint'(vtx_y[i])
            + coef_of(row, 2) * longint'(vtx_z[i]);
        acc += longint'(shift) * 65536;
        acc = (acc + 32768) >>> 16;
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    function automatic bit in_range(logic [15:0] i);
        return 32'(i) < 32'(cfg.vertex_count) && 32'(i) < VERTEX_DEPTH;
    endfunction

    function automatic void emit_tri(logic [15:0] a, logic [15:0] b, logic [15:0] c, bit rev);
        out_item_t t;
        int first, last;
        if (!in_range(a) || !in_range(b) || !in_range(c))
            return;
        first = rev ? int'(c) : int'(a);
        last  = rev ? int'(a) : int'(c);
        t.corner_a_x = xform(cfg.row_x, cfg.shift_x, first);
        t.corner_a_y = xform(cfg.row_y, cfg.shift_y, first);
        t.corner_a_z = xform(cfg.row_z, cfg.shift_z, first);
        t.corner_b_x = xform(cfg.row_x, cfg.shift_x, int'(b));
        t.corner_b_y = xform(cfg.row_y, cfg.shift_y, int'(b));
        t.corner_b_z = xform(cfg.row_z, cfg.shift_z, int'(b));
        t.corner_c_x = xform(cfg.row_x, cfg.shift_x, last);
        t.corner_c_y = xform(cfg.row_y, cfg.shift_y, last);
        t.corner_c_z = xform(cfg.row_z, cfg.shift_z, last);
        tri_expected.insert(tri_expected.size(), t);
    endfunction

    function automatic void assemble(in_item_t it);
        bit base;
        if (it.cmd == CMD_VERTEX)
        begin
            vtx_x[it.vertex_slot] = it.pos_x;
            vtx_y[it.vertex_slot] = it.pos_y;
            vtx_z[it.vertex_slot] = it.pos_z;
            if (!vtx_written[it.vertex_slot])
                filled_slots.insert(filled_slots.size(), int'(it.vertex_slot));
            vtx_written[it.vertex_slot] = 1'b1;
            return;
        end
        base = cfg.solid_reversed ^ winding_flips();
        if (fill == 2'd0)
        begin
            case (it.cmd)
                CMD_STRIP: newer_idx = it.vert_index;
                CMD_LIST:  older_idx = it.vert_index;
                default:   anchor_idx = it.vert_index;
            endcase
            fill = 2'd1;
        end
        else if (fill == 2'd1)
        begin
            if (it.cmd == CMD_STRIP)
                older_idx = newer_idx;
            newer_idx = it.vert_index;
            fill = 2'd2;
        end
        else
        begin
            case (it.cmd)
                CMD_STRIP:
                begin
                    emit_tri(older_idx, newer_idx, it.vert_index, base ^ odd_tri);
                    older_idx = newer_idx;
                    newer_idx = it.vert_index;
                    odd_tri = ~odd_tri;
                end
                CMD_LIST:
                begin
                    emit_tri(older_idx, newer_idx, it.vert_index, base);
                    fill = 2'd0;
                end
                default:
                begin
                    emit_tri(anchor_idx, newer_idx, it.vert_index, base);
                    newer_idx = it.vert_index;
                end
            endcase
        end
        if (it.group_end)
        begin
            fill = 2'd0;
            odd_tri = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_item_t want;
        string names [9];
        names = '{"a_x", "a_y", "a_z", "b_x", "b_y", "b_z", "c_x", "c_y", "c_z"};
        if (rst_n && out_valid && out_ready)
        begin
            if (tri_expected.size() == 0)
            begin
                report_mismatch("unexpected triangle", out_data[31:0], '0);
            end
            else
            begin
                want = tri_expected.pop_front();
                for (int k = 0; k < 9; k++)
                    if (out_data[287-32*k -: 32] !== want[287-32*k -: 32])
                        report_mismatch(names[k], out_data[287-32*k -: 32],
                                        want[287-32*k -: 32]);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            out_ready = 1'b0;
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES)
            begin
                hold_req = 1'b0;
                hold_cnt = 0;
            end
        end
        else if (stall_left > 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready = 1'b1;
            if (jitter && $urandom_range(0, 15) == 0)
                stall_left = $urandom_range(1, 12);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(in_item_t it);
        if (jitter && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        do @(posedge clk); while (!in_ready);
        assemble(it);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (tri_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(reg_idx_t r, logic [63:0] v);
        wait_drain();
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = 6'(8 * int'(r));
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (r)
            REG_ROW_X:   cfg.row_x = v[ROW_W-1:0];
            REG_ROW_Y:   cfg.row_y = v[ROW_W-1:0];
            REG_ROW_Z:   cfg.row_z = v[ROW_W-1:0];
            REG_SHIFT_X: cfg.shift_x = v[31:0];
            REG_SHIFT_Y: cfg.shift_y = v[31:0];
            REG_SHIFT_Z: cfg.shift_z = v[31:0];
            REG_SOLID:   cfg.solid_reversed = v[0];
            default:     cfg.vertex_count = v[CNT_W-1:0];
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(logic [ROW_W-1:0] rx, logic [ROW_W-1:0] ry, logic [ROW_W-1:0] rz,
                              logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                              bit solid, logic [CNT_W-1:0] count);
        cfg_write(REG_ROW_X, 64'(rx));
        cfg_write(REG_ROW_Y, 64'(ry));
        cfg_write(REG_ROW_Z, 64'(rz));
        cfg_write(REG_SHIFT_X, 64'(sx));
        cfg_write(REG_SHIFT_Y, 64'(sy));
        cfg_write(REG_SHIFT_Z, 64'(sz));
        cfg_write(REG_SOLID, 64'(solid));
        cfg_write(REG_VCOUNT, 64'(count));
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_index();
        logic [15:0] i;
        if ($urandom_range(0, 4) == 0)
            i = 16'($urandom);
        else if ($urandom_range(0, 1) == 0)
            i = 16'($urandom_range(0, 31));
        else
            i = 16'(filled_slots[$urandom_range(0, filled_slots.size() - 1)]);
        // any store slot an index may ever reach must hold a vertex
        if (32'(i) < VERTEX_DEPTH && !vtx_written[i])
            i = 16'(filled_slots[$urandom_range(0, filled_slots.size() - 1)]);
        return i;
    endfunction

    task automatic put_vertex(int slot, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        in_item_t it;
        it = '0;
        it.cmd = CMD_VERTEX;
        it.vertex_slot = 12'(slot);
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.group_end = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic put_index(cmd_t c, logic [15:0] i, bit gend);
        in_item_t it;
        it = '0;
        it.cmd = c;
        it.vert_index = i;
        it.group_end = gend;
        send_item(it);
    endtask

    task automatic random_traffic(int n);
        int sent;
        int len;
        int r;
        cmd_t c;
        in_item_t it;
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(0, 9);
            if (r < 2)
            begin
                put_vertex(($urandom_range(0, 3) != 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(0, 4095),
                           rand_coord(), rand_coord(), rand_coord());
                sent++;
            end
            else if (r < 9)
            begin
                c = cmd_t'($urandom_range(1, 3));
                len = (c == CMD_LIST) ? 3 * $urandom_range(1, 3) : $urandom_range(3, 8);
                for (int k = 0; k < len; k++)
                    put_index(c, pick_index(), k == len - 1);
                sent += len;
            end
            else
            begin
                it = '0;
                it.cmd = cmd_t'($urandom_range(1, 3));
                it.vertex_slot = 12'($urandom);
                it.pos_x = $urandom;
                it.pos_y = $urandom;
                it.pos_z = $urandom;
                it.vert_index = pick_index();
                it.group_end = 1'($urandom_range(0, 1));
                send_item(it);
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        set_config(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, 0, 0, 0, 1'b0, 13'd0);
        put_vertex(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        put_vertex(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        put_vertex(2, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        put_vertex(3, 32'hFFFF_8000, 32'h0000_8000, 32'h1234_5678);
        put_vertex(4095, 32'h0, 32'h0, 32'h0);
        // nothing is in range with a zero count
        put_index(CMD_LIST, 16'd0, 1'b0);
        put_index(CMD_LIST, 16'd1, 1'b0);
        put_index(CMD_LIST, 16'd2, 1'b1);
        cfg_write(REG_VCOUNT, 64'd4);
        // strip: alternating winding
        put_index(CMD_STRIP, 16'd0, 1'b0);
        put_index(CMD_STRIP, 16'd1, 1'b0);
        put_index(CMD_STRIP, 16'd2, 1'b0);
        put_index(CMD_STRIP, 16'd3, 1'b0);
        put_index(CMD_STRIP, 16'd0, 1'b1);
        // fan with an out-of-range corner, still advancing
        put_index(CMD_FAN, 16'd3, 1'b0);
        put_index(CMD_FAN, 16'd2, 1'b0);
        put_index(CMD_FAN, 16'hFFFF, 1'b0);
        put_index(CMD_FAN, 16'd1, 1'b0);
        put_index(CMD_FAN, 16'd0, 1'b1);
        // mixed commands in one group
        put_index(CMD_LIST, 16'd1, 1'b0);
        put_index(CMD_STRIP, 16'd2, 1'b0);
        put_index(CMD_FAN, 16'd4, 1'b0);
        put_index(CMD_LIST, 16'd3, 1'b1);
    endtask

    task automatic test_settings();
        set_config(pack_row(70000, -3000, 1200), pack_row(-500, 60000, 800),
                   pack_row(100, 2000, -65536), $urandom, $urandom, $urandom, 1'b0, 13'd32);
        random_traffic(70);
        set_config(pack_row(-65536, 0, 0), ROW_Y_RST, ROW_Z_RST,
                   0, 32'h0001_0000, 0, 1'b1, 13'd32);
        random_traffic(70);
        set_config(ROW_X_RST, ROW_Y_RST, ROW_Z_RST,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 13'd32);
        random_traffic(60);
        set_config(pack_row(32'hFFFFF, 32'hFFFFF, 32'hFFFFF),
                   pack_row(-32'h100000, -32'h100000, -32'h100000),
                   pack_row(32'hFFFFF, -32'h100000, 0), 32'h8000_0000, 32'h7FFF_FFFF, 0,
                   1'b0, 13'd4096);
        random_traffic(60);
        set_config(ROW_W'({$urandom, $urandom}), ROW_W'({$urandom, $urandom}),
                   ROW_W'({$urandom, $urandom}),
                   $urandom, $urandom, $urandom, 1'b1, 13'h1FFF);
        random_traffic(60);
        cfg_write(REG_VCOUNT, 64'd0);
        random_traffic(15);
        set_config(pack_row(65536, 0, 0), pack_row(0, 0, 65536), pack_row(0, 65536, 0),
                   $urandom, 0, $urandom, 1'b0, 13'd13);
        random_traffic(50);
    endtask

    task automatic test_backpressure();
        set_config(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, 32'h0000_0100, 0, 0, 1'b0, 13'd32);
        hold_req = 1'b1;
        // slots 0 to 3 always hold vertices, so every triangle is kept
        for (int k = 0; k < 45; k++)
            put_index(CMD_LIST, 16'(k % 4), k % 3 == 2);
    endtask

    task automatic test_steady_flow();
        wait_drain();
        jitter = 1'b0;
        random_traffic(70);
    endtask

    initial
    begin
        for (int i = 0; i < VERTEX_DEPTH; i++)
            vtx_written[i] = 1'b0;
        anchor_idx = '0;
        older_idx = '0;
        newer_idx = '0;
        fill = '0;
        odd_tri = 1'b0;
        cfg = '0;
        cfg.row_x = ROW_X_RST;
        cfg.row_y = ROW_Y_RST;
        cfg.row_z = ROW_Z_RST;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_settings();
        test_backpressure();
        test_steady_flow();
        wait_drain();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
